/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define HQI_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hqi assertion failed");
`define HQI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
        else $error("hqi assertion failed");
`else
`define HQI_ASSERT(lbl, clk, rstn, prop)
`define HQI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hw/rtl/hqi_pkg.sv */
// types, constants and command/status structs of the histogram quantile interpolator
`timescale 1ns / 1ps

package hqi_pkg;

    localparam int NBINS    = 256;
    localparam int IDX_W    = $clog2(NBINS);
    localparam int LDX_W    = IDX_W + 1;
    localparam int CNT_W    = 16;
    localparam int Q_W      = 16;
    localparam int MODE_W   = 2;
    localparam int OUT_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int TOT_W    = IDX_W + CNT_W;
    localparam int ELEM_W   = CNT_W + 1 + Q_W;
    localparam int WHOLE_W  = ELEM_W - Q_W;
    localparam int POS_W    = IDX_W + Q_W + 1;
    localparam int WIDE_W   = TOT_W + Q_W;
    localparam int DCNT_W   = $clog2(WIDE_W + 1);

    localparam logic [OUT_W-1:0]  POS_MAX  = {OUT_W{1'b1}};
    localparam logic [Q_W-1:0]    HALF_Q   = Q_W'(32768);

    localparam logic [MODE_W-1:0] MODE_INT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUB = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANTILE = 2'd0,
        CFG_MODE     = 2'd1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        RES_UNDER       = 3'd0,
        RES_OVER        = 3'd1,
        RES_SAME        = 3'd2,
        RES_SAME_SUB    = 3'd3,
        RES_BETWEEN     = 3'd4,
        RES_BETWEEN_SUB = 3'd5
    } res_kind_t;

    typedef enum logic [1:0] {
        DIV_OVER = 2'd0,
        DIV_LO   = 2'd1,
        DIV_HI   = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             is_tally;
    } in_t;

    typedef struct packed {
        logic [OUT_W-1:0] position;
        logic             empty_res;
    } out_t;

    typedef struct packed {
        logic      load;
        logic      tally_begin;
        logic      emit_empty;
        logic      walk_step;
        logic      next_step;
        logic      div_start;
        div_sel_t  div_sel;
        logic      lo_latch;
        logic      hi_latch;
        logic      finish;
        res_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic is_tally;
        logic tally_zero;
        logic walk_hit;
        logic same_bin;
        logic bin_nz;
        logic at_first;
        logic at_last;
        logic div_busy;
        logic sub_mode;
    } sts_t;

endpackage

/* hw/rtl/hqi_ram.sv */
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module hqi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/hqi_ctrl.sv */
// controller state machine sequencing load, bin walk, division and result
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hqi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  hqi_pkg::sts_t sts,
    output hqi_pkg::cmd_t cmd,
    output logic          busy
);

    import hqi_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_WALK_A   = 9'b000000010,
        S_WALK_C   = 9'b000000100,
        S_NEXT_A   = 9'b000001000,
        S_NEXT_C   = 9'b000010000,
        S_DIV_SAME = 9'b000100000,
        S_DIV_LO   = 9'b001000000,
        S_DIV_HI   = 9'b010000000,
        S_FIN      = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!sts.is_tally)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (sts.tally_zero)
                    begin
                        cmd.emit_empty = 1'b1;
                    end
                    else
                    begin
                        cmd.tally_begin = 1'b1;
                        state_next      = S_WALK_A;
                    end
                end
            end
            S_WALK_A:
            begin
                state_next = S_WALK_C;
            end
            S_WALK_C:
            begin
                cmd.walk_step = 1'b1;
                if (!sts.walk_hit)
                begin
                    state_next = S_WALK_A;
                end
                else if (sts.at_first)
                begin
                    cmd.finish = 1'b1;
                    cmd.kind   = RES_UNDER;
                    state_next = S_IDLE;
                end
                else if (sts.at_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.kind   = RES_OVER;
                    state_next = S_IDLE;
                end
                else if (sts.same_bin)
                begin
                    if (sts.sub_mode)
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_OVER;
                        state_next    = S_DIV_SAME;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        cmd.kind   = RES_SAME;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_NEXT_A;
                end
            end
            S_NEXT_A:
            begin
                state_next = S_NEXT_C;
            end
            S_NEXT_C:
            begin
                cmd.next_step = 1'b1;
                if (sts.at_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.kind   = RES_OVER;
                    state_next = S_IDLE;
                end
                else if (!sts.bin_nz)
                begin
                    state_next = S_NEXT_A;
                end
                else if (sts.sub_mode)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_LO;
                    state_next    = S_DIV_LO;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.kind   = RES_BETWEEN;
                    state_next = S_IDLE;
                end
            end
            S_DIV_SAME:
            begin
                if (!sts.div_busy)
                begin
                    cmd.finish = 1'b1;
                    cmd.kind   = RES_SAME_SUB;
                    state_next = S_IDLE;
                end
            end
            S_DIV_LO:
            begin
                if (!sts.div_busy)
                begin
                    cmd.lo_latch  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_HI;
                    state_next    = S_DIV_HI;
                end
            end
            S_DIV_HI:
            begin
                if (!sts.div_busy)
                begin
                    cmd.hi_latch = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                cmd.kind   = RES_BETWEEN_SUB;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `HQI_ASSERT_NEXT(a_finish_to_idle, clk, rst_n, cmd.finish, state_reg == S_IDLE)
    `HQI_ASSERT(a_finish_no_div, clk, rst_n, !(cmd.finish && cmd.div_start))
    `HQI_ASSERT(a_idle_div_quiet, clk, rst_n, (state_reg == S_IDLE) |-> !sts.div_busy)

endmodule

/* hw/rtl/hqi_dp.sv */
// datapath: config registers, bin store, cumulative walk, divider and result
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hqi_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [hqi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hqi_pkg::Q_W-1:0]        cfg_data,
    input  hqi_pkg::in_t                   item,
    input  hqi_pkg::cmd_t                  cmd,
    output hqi_pkg::sts_t                  sts,
    output logic                           result_valid,
    output hqi_pkg::out_t                  result
);

    import hqi_pkg::*;

    localparam logic [POS_W-1:0] HALF_P   = POS_W'(HALF_Q);
    localparam logic [POS_W-1:0] ONE_P    = POS_W'(1) << Q_W;
    localparam logic [POS_W-1:0] OVF_INT  = POS_W'(NBINS - 1) << Q_W;
    localparam logic [POS_W-1:0] OVF_FRAC = (POS_W'(NBINS) << Q_W) - HALF_P;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NBINS - 1);

    logic [Q_W-1:0]    quantile_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [LDX_W-1:0]  load_idx_reg;
    logic [ELEM_W-1:0] elem_reg;
    logic [IDX_W-1:0]  scan_reg;
    logic [TOT_W-1:0]  total_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [CNT_W-1:0]  lo_cnt_reg;
    logic [CNT_W-1:0]  hi_cnt_reg;
    logic [POS_W-1:0]  lo_reg;
    logic [POS_W-1:0]  hi_reg;
    logic [WIDE_W-1:0] dq_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              result_valid_reg;
    out_t              result_reg;

    logic [CNT_W-1:0]  bin_q;
    logic              ram_we;
    logic [WHOLE_W-1:0] whole;
    logic [Q_W-1:0]    frac;
    logic [TOT_W-1:0]  tot_sum;
    logic [WIDE_W-1:0] tot_shift;
    logic [WIDE_W-1:0] over;
    logic              frac_mode;
    logic [CNT_W:0]    cnt_p1;
    logic [WIDE_W-1:0] div_q;
    logic [CNT_W:0]    div_shift;
    logic              div_ge;
    logic [POS_W-1:0]  scan_pos;
    logic [POS_W-1:0]  i_pos;
    logic [POS_W-1:0]  j_pos;
    logic [IDX_W-1:0]  bin_gap;
    logic [Q_W+IDX_W-1:0] prod_dist;
    logic [POS_W-1:0]  span;
    logic [Q_W+POS_W-1:0] prod_span;
    logic [POS_W-1:0]  top;
    logic [WIDE_W-1:0] res_w;

    // bin store
    assign ram_we = cmd.load && (load_idx_reg < LDX_W'(NBINS));

    hqi_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NBINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (load_idx_reg[IDX_W-1:0]),
        .wdata (item.count),
        .raddr (scan_reg),
        .rdata (bin_q)
    );

    // walk arithmetic
    assign whole     = elem_reg[ELEM_W-1:Q_W];
    assign frac      = elem_reg[Q_W-1:0];
    assign tot_sum   = total_reg + TOT_W'(bin_q);
    assign tot_shift = {tot_sum, Q_W'(0)};
    assign over      = tot_shift - WIDE_W'(elem_reg);
    assign frac_mode = (mode_reg != MODE_INT);
    assign cnt_p1    = (CNT_W+1)'(item.count) + (CNT_W+1)'(1);

    // status to controller
    always_comb
    begin
        sts.is_tally   = item.is_tally;
        sts.tally_zero = (item.count == '0);
        sts.walk_hit   = (tot_sum >= TOT_W'(whole)) || (scan_reg == LAST_IDX);
        sts.same_bin   = (tot_shift >= WIDE_W'(elem_reg));
        sts.bin_nz     = (bin_q != '0);
        sts.at_first   = (scan_reg == '0);
        sts.at_last    = (scan_reg == LAST_IDX);
        sts.div_busy   = (dcnt_reg != '0);
        sts.sub_mode   = (mode_reg >= MODE_SUB);
    end

    // restoring divider step, a zero divisor gives zero
    assign div_shift = {rem_reg, dq_reg[WIDE_W-1]};
    assign div_ge    = (div_shift >= {1'b0, den_reg});
    assign div_q     = (den_reg == '0) ? '0 : dq_reg;

    // result position
    assign scan_pos  = POS_W'(scan_reg) << Q_W;
    assign i_pos     = POS_W'(i_reg) << Q_W;
    assign j_pos     = POS_W'(j_reg) << Q_W;
    assign bin_gap   = scan_reg - i_reg;
    assign prod_dist = (Q_W+IDX_W)'(frac) * (Q_W+IDX_W)'(bin_gap);
    assign span      = (hi_reg > lo_reg) ? (hi_reg - lo_reg) : '0;
    assign prod_span = (Q_W+POS_W)'(frac) * (Q_W+POS_W)'(span);
    assign top       = i_pos + ONE_P;

    always_comb
    begin
        res_w = '0;
        case (cmd.kind)
            RES_UNDER:
            begin
                res_w = frac_mode ? WIDE_W'(HALF_P) : '0;
            end
            RES_OVER:
            begin
                res_w = frac_mode ? WIDE_W'(OVF_FRAC) : WIDE_W'(OVF_INT);
            end
            RES_SAME:
            begin
                res_w = WIDE_W'(scan_pos) + (frac_mode ? WIDE_W'(HALF_P) : '0);
            end
            RES_SAME_SUB:
            begin
                res_w = (div_q < WIDE_W'(top)) ? (WIDE_W'(top) - div_q) : '0;
            end
            RES_BETWEEN:
            begin
                res_w = WIDE_W'(i_pos) + WIDE_W'(prod_dist >> Q_W)
                      + (frac_mode ? WIDE_W'(HALF_P) : '0);
            end
            RES_BETWEEN_SUB:
            begin
                res_w = WIDE_W'(lo_reg) + WIDE_W'(prod_span >> Q_W);
            end
            default:
            begin
                res_w = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantile_reg     <= HALF_Q;
            mode_reg         <= MODE_INT;
            load_idx_reg     <= '0;
            dcnt_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_QUANTILE))
            begin
                quantile_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_MODE))
            begin
                mode_reg <= cfg_data[MODE_W-1:0];
            end
            if (ram_we)
            begin
                load_idx_reg <= load_idx_reg + LDX_W'(1);
            end
            else if (cmd.tally_begin || cmd.emit_empty)
            begin
                load_idx_reg <= '0;
            end
            if (cmd.div_start)
            begin
                dcnt_reg <= DCNT_W'(WIDE_W);
            end
            else if (dcnt_reg != '0)
            begin
                dcnt_reg <= dcnt_reg - DCNT_W'(1);
            end
            result_valid_reg <= cmd.finish || cmd.emit_empty;
        end
    end

    // walk, divider and result payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.tally_begin)
        begin
            elem_reg  <= ELEM_W'(cnt_p1) * ELEM_W'(quantile_reg);
            scan_reg  <= '0;
            total_reg <= '0;
        end
        if (cmd.walk_step)
        begin
            total_reg  <= tot_sum;
            i_reg      <= scan_reg;
            lo_cnt_reg <= bin_q;
            scan_reg   <= scan_reg + IDX_W'(1);
        end
        if (cmd.next_step)
        begin
            j_reg      <= scan_reg;
            hi_cnt_reg <= bin_q;
            scan_reg   <= scan_reg + IDX_W'(1);
        end
        if (cmd.lo_latch)
        begin
            lo_reg <= top - POS_W'(div_q);
        end
        if (cmd.hi_latch)
        begin
            hi_reg <= j_pos + POS_W'(div_q);
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            case (cmd.div_sel)
                DIV_OVER:
                begin
                    dq_reg  <= over;
                    den_reg <= bin_q;
                end
                DIV_LO:
                begin
                    dq_reg  <= WIDE_W'(HALF_Q);
                    den_reg <= lo_cnt_reg;
                end
                DIV_HI:
                begin
                    dq_reg  <= WIDE_W'(HALF_Q);
                    den_reg <= hi_cnt_reg;
                end
                default:
                begin
                    dq_reg  <= '0;
                    den_reg <= '0;
                end
            endcase
        end
        else if (dcnt_reg != '0)
        begin
            rem_reg <= div_ge ? CNT_W'(div_shift - {1'b0, den_reg}) : CNT_W'(div_shift);
            dq_reg  <= {dq_reg[WIDE_W-2:0], div_ge};
        end
        if (cmd.emit_empty)
        begin
            result_reg.position  <= '0;
            result_reg.empty_res <= 1'b1;
        end
        else if (cmd.finish)
        begin
            result_reg.position  <= (res_w > WIDE_W'(POS_MAX)) ? POS_MAX : res_w[OUT_W-1:0];
            result_reg.empty_res <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `HQI_ASSERT(a_div_start_idle, clk, rst_n, cmd.div_start |-> (dcnt_reg == '0))
    `HQI_ASSERT(a_load_idx_bound, clk, rst_n, load_idx_reg <= LDX_W'(NBINS))
    `HQI_ASSERT_NEXT(a_empty_result, clk, rst_n, cmd.emit_empty, result_valid && result.empty_res)

endmodule

/* hw/rtl/histogram_quantile_interpolator_core.sv */
// top level of the histogram quantile interpolator
`timescale 1ns / 1ps

// Histogram quantile interpolator. A transaction with is_tally low stores one bin
// count (underflow bin first, overflow bin last). A transaction with is_tally high
// evaluates the loaded histogram and gives exactly one result, strobed on
// result_valid for a single cycle; the receiver cannot stall, so it must take the
// result in that cycle. A zero tally answers on the next cycle. Otherwise the
// cumulative walk reads the bin memory bin by bin in order, and sub-bin mode adds
// one or two passes of the bit-serial divider; busy stays high until the result
// is issued.
// Configuration writes are always ready and must only be issued while busy is low.

module histogram_quantile_interpolator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  hqi_pkg::in_t                   item,
    output logic                           result_valid,
    output hqi_pkg::out_t                  result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hqi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hqi_pkg::Q_W-1:0]        cfg_data
);

    import hqi_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // controller
    hqi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath
    hqi_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* tb/sv/histogram_quantile_interpolator_core_tb.sv */
// self-checking testbench for the histogram quantile interpolator core
`timescale 1ns / 1ps

module histogram_quantile_interpolator_core_tb;
    import hqi_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_OPS      = 40;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 700;

    typedef struct {
        bit              is_cfg;
        in_t             payload;
        cfg_idx_t        reg_sel;
        logic [Q_W-1:0]  value;
    } stim_op_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    in_t                  item = '0;
    logic                 result_valid;
    out_t                 result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [Q_W-1:0]       cfg_data = '0;

    stim_op_t pending_ops[$];
    out_t     expected_results[$];
    int       fail_count = 0;
    int       stall_cycles = 0;
    int       gap_left = 0;
    int       quiet_cycles = 0;
    bit       drv_start;
    bit       drv_cfg;

    // shadow copy of the histogram and registers
    logic [CNT_W-1:0]  bin_shadow[NBINS];
    int                fill_ptr = 0;
    logic [Q_W-1:0]    quantile_shadow = Q_W'(32768);
    logic [MODE_W-1:0] mode_shadow = MODE_INT;

    histogram_quantile_interpolator_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // position for the end stop of the histogram
    function automatic longint unsigned overflow_position(bit frac_mode);
        return frac_mode ? ((longint'(NBINS) << 16) - 32768) : (longint'(NBINS - 1) << 16);
    endfunction

    function automatic longint unsigned half_step(longint unsigned n);
        return (n != 0) ? 64'd32768 / n : 64'd0;
    endfunction

    // cumulative walk and interpolation over the shadow histogram
    function automatic longint unsigned quantile_position(longint unsigned tally);
        bit              frac_mode;
        bit              sub_mode;
        longint unsigned elem, whole, frac, total;
        longint unsigned lo_cnt, base, over, step, top, lo, hi, span, p;
        int              i;
        int              j;
        frac_mode = (mode_shadow != MODE_INT);
        sub_mode  = (mode_shadow >= MODE_SUB);
        elem  = (tally + 1) * longint'(quantile_shadow);
        whole = elem >> 16;
        frac  = elem & 64'hFFFF;
        total = 0;
        for (i = 0; i < NBINS; i++)
        begin
            total += bin_shadow[i];
            if (total >= whole)
                break;
        end
        if (i == 0)
            return frac_mode ? 64'd32768 : 64'd0;
        if (i >= NBINS - 1)
            return overflow_position(frac_mode);
        lo_cnt = bin_shadow[i];
        base   = longint'(i) << 16;
        // element lands inside bin i
        if ((total << 16) >= elem)
        begin
            if (!frac_mode)
                return base;
            if (!sub_mode)
                return base + 32768;
            over = (total << 16) - elem;
            step = (lo_cnt != 0) ? over / lo_cnt : 0;
            top  = base + 65536;
            return (step < top) ? top - step : 0;
        end
        // element lies between bin i and the next populated bin
        for (j = i + 1; j < NBINS; j++)
        begin
            if (bin_shadow[j] != 0)
                break;
        end
        if (j >= NBINS - 1)
            return overflow_position(frac_mode);
        if (!sub_mode)
        begin
            p = base + ((frac * longint'(j - i)) >> 16);
            return frac_mode ? p + 32768 : p;
        end
        lo   = base + 65536 - half_step(lo_cnt);
        hi   = (longint'(j) << 16) + half_step(bin_shadow[j]);
        span = (hi > lo) ? hi - lo : 0;
        return lo + ((frac * span) >> 16);
    endfunction

    // update the shadow state for one accepted transaction
    function automatic void predict_item(in_t it);
        out_t            exp_res;
        longint unsigned p;
        if (!it.is_tally)
        begin
            if (fill_ptr < NBINS)
            begin
                bin_shadow[fill_ptr] = it.count;
                fill_ptr++;
            end
            return;
        end
        fill_ptr = 0;
        if (it.count == 0)
        begin
            exp_res.position  = '0;
            exp_res.empty_res = 1'b1;
        end
        else
        begin
            p = quantile_position(longint'(it.count));
            exp_res.position  = (p > 64'hFFFFFF) ? POS_MAX : p[OUT_W-1:0];
            exp_res.empty_res = 1'b0;
        end
        expected_results.push_back(exp_res);
    endfunction

    task automatic push_bin(logic [CNT_W-1:0] v);
        stim_op_t op;
        op = '{is_cfg: 1'b0, payload: '{count: v, is_tally: 1'b0}, reg_sel: CFG_QUANTILE, value: '0};
        pending_ops.push_back(op);
    endtask

    task automatic push_tally(logic [CNT_W-1:0] v);
        stim_op_t op;
        op = '{is_cfg: 1'b0, payload: '{count: v, is_tally: 1'b1}, reg_sel: CFG_QUANTILE, value: '0};
        pending_ops.push_back(op);
    endtask

    task automatic push_cfg(cfg_idx_t sel, logic [Q_W-1:0] v);
        stim_op_t op;
        op = '{is_cfg: 1'b1, payload: '0, reg_sel: sel, value: v};
        pending_ops.push_back(op);
    endtask

    function automatic logic [CNT_W-1:0] random_bin();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return '0;
        if (pick < 8)
            return CNT_W'($urandom_range(1, 400));
        if (pick == 8)
            return CNT_W'(65535);
        return CNT_W'($urandom);
    endfunction

    function automatic logic [CNT_W-1:0] random_tally();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return CNT_W'(65535);
        if (pick == 2)
            return CNT_W'($urandom);
        return CNT_W'($urandom_range(1, 20000));
    endfunction

    // driver: pops pending transactions, random idle bursts, config only when drained
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left     = 0;
            quiet_cycles = 0;
        end
        else
        begin
            drv_start = 1'b0;
            drv_cfg   = 1'b0;
            if (gap_left > 0)
                gap_left--;
            if ((start && !busy) || (cfg_valid && cfg_ready))
            begin
                void'(pending_ops.pop_front());
                if (start && pending_ops.size() >= TAIL_OPS && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 12);
            end
            if (start || busy || expected_results.size() != 0)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (gap_left == 0 && pending_ops.size() != 0)
            begin
                if (pending_ops[0].is_cfg)
                begin
                    if (quiet_cycles >= SETTLE_CYCLES)
                    begin
                        drv_cfg = 1'b1;
                        cfg_index <= pending_ops[0].reg_sel;
                        cfg_data  <= pending_ops[0].value;
                    end
                end
                else
                begin
                    drv_start = 1'b1;
                    item <= pending_ops[0].payload;
                end
            end
            start     <= drv_start;
            cfg_valid <= drv_cfg;
        end
    end

    // monitor: predicts on accepted transactions and checks each result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_QUANTILE)
                    quantile_shadow = cfg_data;
                else if (cfg_index == CFG_MODE)
                    mode_shadow = cfg_data[MODE_W-1:0];
            end
            if (start && !busy)
                predict_item(item);
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: position %0h empty_res %0b",
                           result.position, result.empty_res);
                    fail_count++;
                end
                else
                begin
                    out_t exp_res;
                    exp_res = expected_results.pop_front();
                    if (result.position !== exp_res.position)
                    begin
                        $error("position: expected %0h actual %0h",
                               exp_res.position, result.position);
                        fail_count++;
                    end
                    if (result.empty_res !== exp_res.empty_res)
                    begin
                        $error("empty_res: expected %0b actual %0b",
                               exp_res.empty_res, result.empty_res);
                        fail_count++;
                    end
                end
            end
            // watchdog on cycles without any transaction
            if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        logic [Q_W-1:0] q_pick;
        int             n_load;
        int             m;

        // opening load writes every bin once, sparse, plus ignored extras
        push_cfg(CFG_QUANTILE, Q_W'(32768));
        push_cfg(CFG_MODE, Q_W'(MODE_INT));
        for (int b = 0; b < NBINS; b++)
        begin
            if (b == NBINS - 1)
                push_bin(CNT_W'(5));
            else
                push_bin(($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(1, 300)) : '0);
        end
        push_bin(CNT_W'(65535));
        push_bin(CNT_W'(65535));
        push_tally(CNT_W'($urandom_range(1, 20000)));

        // directed: empty, extreme tallies and underflow in every mode
        for (m = 0; m < 4; m++)
        begin
            push_cfg(CFG_MODE, Q_W'(m));
            push_tally('0);
            push_tally(CNT_W'(1));
            push_tally(CNT_W'(65535));
            push_bin(CNT_W'(65535));
            push_tally(CNT_W'(3));
        end
        push_cfg(CFG_QUANTILE, Q_W'(65535));
        push_tally(CNT_W'(65535));
        push_cfg(CFG_QUANTILE, Q_W'(1));
        push_tally(CNT_W'(65535));

        // random short reloads of the low bins, settings swept per group
        for (int g = 0; g < 6; g++)
        begin
            case (g)
                0: q_pick = Q_W'(1);
                1: q_pick = Q_W'(65535);
                2: q_pick = Q_W'(32768);
                default: q_pick = Q_W'($urandom_range(1, 65535));
            endcase
            push_cfg(CFG_QUANTILE, q_pick);
            push_cfg(CFG_MODE, Q_W'((g + 1) % 4));
            for (int h = 0; h < 10; h++)
            begin
                n_load = $urandom_range(0, 4);
                for (int k = 0; k < n_load; k++)
                    push_bin(random_bin());
                push_tally(random_tally());
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
